// ===== design/fcal_pkg.sv =====
// ---------------------------------------------------------------------------
// Fixed-capacity array list package
// Shared widths, request codes, status codes and sequencer states.
// ---------------------------------------------------------------------------
package fcal_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int WORD_W       = 32;
	localparam int POS_W        = 5;
	localparam int REQ_W        = 3;
	localparam int CNT_OUT_W    = 6;
	localparam int STAT_W       = 2;
	localparam int IN_DATA_W    = 40;
	localparam int OUT_DATA_W   = 40;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_INSERT     = 3'd4,
		REQ_GET        = 3'd5,
		REQ_SET        = 3'd6,
		REQ_NONE       = 3'd7
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_BEYOND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_RD   = 3'd1,
		ST_WR   = 3'd2,
		ST_FIN  = 3'd3,
		ST_GET  = 3'd4
	} state_t;

endpackage

// ===== design/fcal_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module fcal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/fixed_capacity_array_list_unit.sv =====
// ---------------------------------------------------------------------------
// Fixed-capacity array list unit
// Ordered list of signed 32-bit words with shifting insert and pop front.
// ---------------------------------------------------------------------------
//  Channel   Direction  Contents (lowest bit first)
//  s_axis    in         req_type[2:0], position[7:3], value[39:8]
//  m_axis    out        read_value[31:0], count[37:32], status[39:38]
//
//  Push back, pop back, set, appends and failed requests load their result when accepted;
//  get loads it in ST_GET. Entry-moving inserts, push fronts and pop fronts alternate ST_RD
//  and ST_WR: every moved entry costs one read and one write of the single-port-pair RAM.
//  Reset clears the count and a valid bit per slot; an unwritten slot reads 0.
//  The input is held off while a request is in work or while a finished
//  result is still waiting and is not being taken.
// ---------------------------------------------------------------------------
module fixed_capacity_array_list_unit #(
	parameter int CAPACITY = fcal_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// req_type[2:0], position[7:3], value[39:8]
	input  logic [fcal_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// read_value[31:0], count[37:32], status[39:38]
	output logic [fcal_pkg::OUT_DATA_W-1:0]  m_tdata
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = fcal_pkg::WORD_W;

	fcal_pkg::state_t state_q, state_nxt;

	logic [CW-1:0]       count_q, count_nxt;
	logic [AW-1:0]       cursor_q, slot_q;
	logic                dir_up_q;
	logic [WW-1:0]       val_q;
	logic [CAPACITY-1:0] valid_q;
	logic                rd_valid_q;

	logic                m_tvalid_q;
	logic [WW-1:0]       out_value_q;
	logic [fcal_pkg::CNT_OUT_W-1:0] out_count_q;
	fcal_pkg::status_t   out_status_q;

	// Request fields
	fcal_pkg::req_t           req;
	logic [fcal_pkg::POS_W-1:0] pos;
	logic [WW-1:0]            val;
	logic [AW-1:0]            pos_idx, count_idx, ins_slot;
	logic                     in_acc, out_free, full, empty, pos_ok;

	// Decode of an incoming request
	logic               d_wr, d_up, d_down, d_get, d_inc, d_dec;
	logic [AW-1:0]      d_addr;
	fcal_pkg::status_t  d_status;

	// Datapath controls
	logic               ram_wr, ram_rd;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [WW-1:0]      ram_wdata, ram_rdata, rd_word;
	logic               ld_out, cnt_inc, cnt_dec;
	logic [WW-1:0]      ld_value;
	fcal_pkg::status_t  ld_status;
	logic               down_more;

	assign req       = fcal_pkg::req_t'(s_tdata[2:0]);
	assign pos       = s_tdata[7:3];
	assign val       = s_tdata[39:8];
	assign pos_idx   = AW'(pos);
	assign count_idx = AW'(count_q);
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign pos_ok    = (32'(pos) < 32'(CAPACITY));
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == fcal_pkg::ST_IDLE) && out_free;
	assign in_acc    = s_tvalid && s_tready;
	assign rd_word   = rd_valid_q ? ram_rdata : '0;
	assign down_more = ((CW + 1)'(cursor_q) + (CW + 1)'(2)) < (CW + 1)'(count_q);

	always_comb begin
		if (req == fcal_pkg::REQ_PUSH_FRONT) begin
			ins_slot = '0;
		end else if (32'(pos) < 32'(count_q)) begin
			ins_slot = pos_idx;
		end else begin
			ins_slot = count_idx;
		end
	end

	always_comb begin
		d_wr     = 1'b0;
		d_up     = 1'b0;
		d_down   = 1'b0;
		d_get    = 1'b0;
		d_inc    = 1'b0;
		d_dec    = 1'b0;
		d_addr   = pos_idx;
		d_status = fcal_pkg::STAT_OK;
		case (req)
			fcal_pkg::REQ_PUSH_FRONT, fcal_pkg::REQ_INSERT: begin
				if (full) begin
					d_status = fcal_pkg::STAT_FULL;
				end else if (ins_slot == count_idx) begin
					d_wr   = 1'b1;
					d_addr = ins_slot;
					d_inc  = 1'b1;
				end else begin
					d_up = 1'b1;
				end
			end
			fcal_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					d_status = fcal_pkg::STAT_FULL;
				end else begin
					d_wr   = 1'b1;
					d_addr = count_idx;
					d_inc  = 1'b1;
				end
			end
			fcal_pkg::REQ_POP_FRONT: begin
				if (empty) begin
					d_status = fcal_pkg::STAT_EMPTY;
				end else if (count_q > CW'(1)) begin
					d_down = 1'b1;
				end else begin
					d_dec = 1'b1;
				end
			end
			fcal_pkg::REQ_POP_BACK: begin
				if (empty) begin
					d_status = fcal_pkg::STAT_EMPTY;
				end else begin
					d_dec = 1'b1;
				end
			end
			fcal_pkg::REQ_GET: begin
				if (pos_ok) begin
					d_get = 1'b1;
				end else begin
					d_status = fcal_pkg::STAT_BEYOND;
				end
			end
			fcal_pkg::REQ_SET: begin
				if (pos_ok) begin
					d_wr = 1'b1;
				end else begin
					d_status = fcal_pkg::STAT_BEYOND;
				end
			end
			default: begin
			end
		endcase
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fcal_pkg::ST_IDLE: begin
				if (in_acc && (d_up || d_down)) begin
					state_nxt = fcal_pkg::ST_RD;
				end else if (in_acc && d_get) begin
					state_nxt = fcal_pkg::ST_GET;
				end
			end
			fcal_pkg::ST_RD: state_nxt = fcal_pkg::ST_WR;
			fcal_pkg::ST_WR: begin
				if (dir_up_q) begin
					state_nxt = (cursor_q - AW'(1) == slot_q) ? fcal_pkg::ST_FIN
					                                         : fcal_pkg::ST_RD;
				end else begin
					state_nxt = down_more ? fcal_pkg::ST_RD : fcal_pkg::ST_IDLE;
				end
			end
			fcal_pkg::ST_FIN: state_nxt = fcal_pkg::ST_IDLE;
			fcal_pkg::ST_GET: state_nxt = fcal_pkg::ST_IDLE;
			default:          state_nxt = fcal_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: RAM port controls, count update and result load
	always_comb begin
		ram_wr    = 1'b0;
		ram_waddr = d_addr;
		ram_wdata = val;
		ram_rd    = 1'b0;
		ram_raddr = pos_idx;
		ld_out    = 1'b0;
		ld_value  = '0;
		ld_status = fcal_pkg::STAT_OK;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		case (state_q)
			fcal_pkg::ST_IDLE: begin
				ram_wr    = in_acc && d_wr;
				ram_rd    = in_acc && d_get;
				ld_out    = in_acc && !(d_up || d_down || d_get);
				ld_status = d_status;
				cnt_inc   = in_acc && d_inc;
				cnt_dec   = in_acc && d_dec;
			end
			fcal_pkg::ST_RD: begin
				ram_rd    = 1'b1;
				ram_raddr = dir_up_q ? cursor_q - AW'(1) : cursor_q + AW'(1);
			end
			fcal_pkg::ST_WR: begin
				ram_wr    = 1'b1;
				ram_waddr = cursor_q;
				ram_wdata = rd_word;
				if (!dir_up_q && !down_more) begin
					ld_out  = 1'b1;
					cnt_dec = 1'b1;
				end
			end
			fcal_pkg::ST_FIN: begin
				ram_wr    = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = val_q;
				ld_out    = 1'b1;
				cnt_inc   = 1'b1;
			end
			fcal_pkg::ST_GET: begin
				ld_out   = 1'b1;
				ld_value = rd_word;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (cnt_inc) begin
			count_nxt = count_q + CW'(1);
		end else if (cnt_dec) begin
			count_nxt = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fcal_pkg::ST_IDLE;
			count_q    <= '0;
			valid_q    <= '0;
			m_tvalid_q <= 1'b0;
			rd_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (ram_wr) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (ram_rd) begin
				rd_valid_q <= valid_q[ram_raddr];
			end
			if (ld_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_q    <= val;
			slot_q   <= ins_slot;
			dir_up_q <= d_up;
			cursor_q <= d_up ? count_idx : '0;
		end else if (state_q == fcal_pkg::ST_WR) begin
			cursor_q <= dir_up_q ? cursor_q - AW'(1) : cursor_q + AW'(1);
		end
		if (ld_out) begin
			out_value_q  <= ld_value;
			out_count_q  <= fcal_pkg::CNT_OUT_W'(count_nxt);
			out_status_q <= ld_status;
		end
	end

	fcal_ram #(
		.WIDTH (WW),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_rd),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_status_q, out_count_q, out_value_q};

endmodule
